// ----- rtl/bucketed_hash_table_engine_defines.svh -----
// Assertion macros shared by the hash table engine RTL.
`ifndef BUCKETED_HASH_TABLE_ENGINE_DEFINES_SVH
`define BUCKETED_HASH_TABLE_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BHTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bhte: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define BHTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bhte: next-cycle check failed");
`else
`define BHTE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BHTE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/bhte_pkg.sv -----
// Constants, codes and control types of the bucketed hash table engine.
`default_nettype none
package bhte_pkg;
	localparam int NUM_BUCKETS = 64;
	localparam int WAYS        = 5;
	localparam int KEY_BYTES   = 8;
	localparam int SLOTS       = NUM_BUCKETS * WAYS;

	localparam int  BKT_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam bit  BKT_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
	localparam int  ADDR_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int  WAY_W    = $clog2(WAYS + 1);
	localparam int  WIDX_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int  COUNT_W  = $clog2(SLOTS + 1);

	localparam int KIND_W   = 2;
	localparam int KEY_W    = 64;
	localparam int VAL_W    = 64;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 9;

	localparam logic [KEY_W-1:0] HASH_SEED  = 64'd5381;
	localparam int               HASH_SHIFT = 5;

	typedef enum logic [KIND_W-1:0] {
		KIND_GET    = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_SET    = 2'd2,
		KIND_REMOVE = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_PRESENT   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic hash;
		logic modr;
		logic base;
		logic scan;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hash_last;
		logic mod_last;
		logic scan_last;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

// ----- rtl/bhte_req_if.sv -----
// Request channel of the hash table engine.
`default_nettype none
interface bhte_req_if import bhte_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0]  key;
	logic [VAL_W-1:0]  value;

	modport source (output valid, output kind, output key, output value, input ready);
	modport sink (input valid, input kind, input key, input value, output ready);
endinterface
`default_nettype wire

// ----- rtl/bhte_rsp_if.sv -----
// Response channel of the hash table engine.
`default_nettype none
interface bhte_rsp_if import bhte_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                was_present;
	logic [VAL_W-1:0]    value_out;
	logic [ENTRY_W-1:0]  entry_count;

	modport source (output valid, output status, output was_present, output value_out,
		output entry_count, input ready);
	modport sink (input valid, input status, input was_present, input value_out,
		input entry_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/bhte_ctrl.sv -----
// Sequencing state machine of the hash table engine.
`default_nettype none
module bhte_ctrl import bhte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic ready,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_HASH   = 6'b000010,
		S_MOD    = 6'b000100,
		S_BASE   = 6'b001000,
		S_SCAN   = 6'b010000,
		S_COMMIT = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				ready    = 1'b1;
				cmd.load = req_valid;
				if (req_valid) begin
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash = 1'b1;
				if (sts.hash_last) begin
					state_d = BKT_POW2 ? S_BASE : S_MOD;
				end
			end
			S_MOD: begin
				cmd.modr = 1'b1;
				if (sts.mod_last) begin
					state_d = S_BASE;
				end
			end
			S_BASE: begin
				cmd.base = 1'b1;
				state_d  = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/bhte_datapath.sv -----
// Hash unit, bucket stores, way scan and response register of the engine.
`default_nettype none
module bhte_datapath import bhte_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [KIND_W-1:0]   req_kind,
	input  logic [KEY_W-1:0]    req_key,
	input  logic [VAL_W-1:0]    req_value,
	input  logic                rsp_ready,
	output logic                rsp_valid,
	output logic [STATUS_W-1:0] rsp_status,
	output logic                rsp_was_present,
	output logic [VAL_W-1:0]    rsp_value_out,
	output logic [ENTRY_W-1:0]  rsp_entry_count
);
	// Stores: keys and values by slot, used flags by bucket row.
	logic [KEY_W-1:0] key_mem [SLOTS];
	logic [VAL_W-1:0] val_mem [SLOTS];
	logic [WAYS-1:0]  used_mem [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0] row_valid_q;

	logic [KIND_W-1:0] kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [KEY_W-1:0]  hash_q;
	logic [2:0]        hcnt_q;
	logic [BKT_W-1:0]  rem_q;
	logic [5:0]        mcnt_q;
	logic [BKT_W-1:0]  bucket_q;
	logic [ADDR_W-1:0] base_q;
	logic [WAY_W-1:0]  wc_q;
	logic              rd_vld_q;
	logic [WIDX_W-1:0] rd_way_q;
	logic [KEY_W-1:0]  key_rd_q;
	logic [VAL_W-1:0]  val_rd_q;
	logic [WAYS-1:0]   used_rd_q;
	logic              row_ok_q;
	logic              hit_q;
	logic [WIDX_W-1:0] hit_way_q;
	logic [VAL_W-1:0]  hit_val_q;
	logic              free_q;
	logic [WIDX_W-1:0] free_way_q;
	logic [COUNT_W-1:0] count_q;
	logic              out_valid_q;

	logic [7:0]        hbyte;
	logic [BKT_W:0]    rem_sh;
	logic [BKT_W-1:0]  bkt;
	logic [WAYS-1:0]   used_row;
	logic              way_used;
	logic [ADDR_W-1:0] rd_addr;

	logic               wr_key, wr_val, wr_row;
	logic [WIDX_W-1:0]  wr_way;
	logic [ADDR_W-1:0]  wr_addr;
	logic [WAYS-1:0]    new_row;
	logic [COUNT_W-1:0] new_count;
	status_t            status_c;
	logic [VAL_W-1:0]   vout_c;

	assign hbyte    = key_q[8*hcnt_q +: 8];
	assign rem_sh   = {rem_q, hash_q[mcnt_q]};
	assign bkt      = BKT_POW2 ? (BKT_W'(hash_q) & BKT_W'(NUM_BUCKETS - 1)) : rem_q;
	assign used_row = used_rd_q & {WAYS{row_ok_q}};
	assign way_used = used_row[rd_way_q];
	assign rd_addr  = base_q + ADDR_W'(wc_q);

	assign sts.hash_last = (hcnt_q == 3'(KEY_BYTES - 1));
	assign sts.mod_last  = (mcnt_q == 6'd0);
	assign sts.scan_last = (wc_q == WAY_W'(WAYS));
	assign sts.out_free  = !out_valid_q || rsp_ready;

	// Request capture, hashing and bucket reduction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req_kind;
			key_q  <= req_key;
			val_q  <= req_value;
			hash_q <= HASH_SEED;
			hcnt_q <= 3'd0;
			rem_q  <= '0;
			mcnt_q <= 6'd63;
		end
		if (cmd.hash) begin
			hash_q <= (hash_q << HASH_SHIFT) + hash_q + KEY_W'(hbyte);
			hcnt_q <= hcnt_q + 3'd1;
		end
		if (cmd.modr) begin
			if (rem_sh >= (BKT_W+1)'(NUM_BUCKETS)) begin
				rem_q <= BKT_W'(rem_sh - (BKT_W+1)'(NUM_BUCKETS));
			end else begin
				rem_q <= BKT_W'(rem_sh);
			end
			mcnt_q <= mcnt_q - 6'd1;
		end
		if (cmd.base) begin
			bucket_q <= bkt;
			base_q   <= ADDR_W'(bkt * WAYS);
		end
	end

	// Way scan: one slot read issued per cycle, the previous one compared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q     <= '0;
			rd_vld_q <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
		end else if (cmd.base) begin
			wc_q     <= '0;
			rd_vld_q <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
		end else if (cmd.scan) begin
			rd_vld_q <= !sts.scan_last;
			if (!sts.scan_last) begin
				wc_q <= wc_q + WAY_W'(1);
			end
			if (rd_vld_q) begin
				if (!way_used && !free_q) begin
					free_q <= 1'b1;
				end
				if (way_used && key_rd_q == key_q && !hit_q) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && !sts.scan_last) begin
			rd_way_q <= WIDX_W'(wc_q);
		end
		if (cmd.scan && rd_vld_q) begin
			if (!way_used && !free_q) begin
				free_way_q <= rd_way_q;
			end
			if (way_used && key_rd_q == key_q && !hit_q) begin
				hit_way_q <= rd_way_q;
				hit_val_q <= val_rd_q;
			end
		end
	end

	// Decision for the finished scan.
	always_comb begin
		wr_key    = 1'b0;
		wr_val    = 1'b0;
		wr_row    = 1'b0;
		wr_way    = hit_way_q;
		new_row   = used_row;
		new_count = count_q;
		status_c  = ST_OK;
		vout_c    = '0;
		case (kind_t'(kind_q))
			KIND_GET: begin
				if (hit_q) begin
					vout_c = hit_val_q;
				end else begin
					status_c = ST_NOT_FOUND;
				end
			end
			KIND_REMOVE: begin
				if (hit_q) begin
					wr_row            = 1'b1;
					new_row[hit_way_q] = 1'b0;
					new_count         = count_q - COUNT_W'(1);
				end else begin
					status_c = ST_NOT_FOUND;
				end
			end
			KIND_ADD, KIND_SET: begin
				if (hit_q) begin
					if (kind_t'(kind_q) == KIND_ADD) begin
						status_c = ST_PRESENT;
					end else begin
						wr_val = 1'b1;
						vout_c = val_q;
					end
				end else if (free_q) begin
					wr_way              = free_way_q;
					wr_key              = 1'b1;
					wr_val              = 1'b1;
					wr_row              = 1'b1;
					new_row[free_way_q] = 1'b1;
					new_count           = count_q + COUNT_W'(1);
					vout_c              = val_q;
				end else begin
					status_c = ST_FULL;
				end
			end
			default: begin
				status_c = ST_OK;
			end
		endcase
	end

	assign wr_addr = base_q + ADDR_W'(wr_way);

	// Slot stores.
	always_ff @(posedge clk) begin
		if (cmd.scan && !sts.scan_last) begin
			key_rd_q <= key_mem[rd_addr];
			val_rd_q <= val_mem[rd_addr];
		end
		if (cmd.commit && wr_key) begin
			key_mem[wr_addr] <= key_q;
		end
		if (cmd.commit && wr_val) begin
			val_mem[wr_addr] <= val_q;
		end
	end

	// Used-flag rows; a row never written reads as all free.
	always_ff @(posedge clk) begin
		if (cmd.base) begin
			used_rd_q <= used_mem[bkt];
		end
		if (cmd.commit && wr_row) begin
			used_mem[bucket_q] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			row_ok_q    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.base) begin
				row_ok_q <= row_valid_q[bkt];
			end
			if (cmd.commit && wr_row) begin
				row_valid_q[bucket_q] <= 1'b1;
			end
			if (cmd.commit) begin
				count_q     <= new_count;
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_status      <= status_c;
			rsp_was_present <= hit_q;
			rsp_value_out   <= vout_c;
			rsp_entry_count <= ENTRY_W'(new_count);
		end
	end

	assign rsp_valid = out_valid_q;
endmodule
`default_nettype wire

// ----- rtl/bucketed_hash_table_engine.sv -----
// Top level of the bucketed key/value hash table engine.
//
//   Channel | Direction | Handshake    | Payload
//   req     | in        | valid/ready  | kind, key, value
//   rsp     | out       | valid/ready  | status, was_present, value_out, entry_count
//
// Each request runs from acceptance to the result register through the hash,
// one djb2 step per key byte, the bucket base, one slot read per way through the
// single store read port plus a final compare, and the write-back. Where the
// bucket count is not a power of two, a bit-serial reduction over all 64 hash
// bits follows the hash. Reset clears the used-flag row marks at once, so no
// clearing pass is needed. A result that waits for rsp.ready holds the
// write-back only when a second result would need the register; the next
// request is accepted as soon as the previous one has been written back.
`default_nettype none
`include "bucketed_hash_table_engine_defines.svh"
module bucketed_hash_table_engine import bhte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bhte_req_if.sink   req,
	bhte_rsp_if.source rsp
);
	cmd_t cmd;
	sts_t sts;
	logic ctrl_ready;

	// The controller steps the request through hash, scan and write-back.
	bhte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.ready     (ctrl_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the stores, the hash and the response register.
	bhte_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_kind        (req.kind),
		.req_key         (req.key),
		.req_value       (req.value),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_status      (rsp.status),
		.rsp_was_present (rsp.was_present),
		.rsp_value_out   (rsp.value_out),
		.rsp_entry_count (rsp.entry_count)
	);

	assign req.ready = ctrl_ready;

	// The engine must be busy in the cycle after it takes a request.
`BHTE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	// Write-back may only happen when the response register can take it.
`BHTE_ASSERT_IMPL(a_commit_slot_free, clk, arst_n, cmd.commit, sts.out_free)
	// The entry count can never exceed the table size.
`BHTE_ASSERT_IMPL(a_count_bound, clk, arst_n, rsp.valid, rsp.entry_count <= ENTRY_W'(SLOTS))
	// A full bucket is only reported for a key that was absent.
`BHTE_ASSERT_IMPL(a_full_absent, clk, arst_n, rsp.valid && (rsp.status == ST_FULL),
	!rsp.was_present)
endmodule
`default_nettype wire
